/* rtl/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants
// Q16.16 constants, FSM state and op codes, control structs, saturation helper.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int LEGS      = 4;
  localparam int LEG_W     = 2;
  localparam int DW        = 32;
  localparam int FRAC_BITS = 16;

  localparam longint Q_ONE    = 64'sd1 <<< FRAC_BITS;
  localparam longint ALPHA_LO = (Q_ONE + 5) / 10;
  localparam longint ALPHA_HI = (2 * Q_ONE + 5) / 10;
  localparam longint TICK_Q   = (Q_ONE + 50) / 100;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARM  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_SEED, S_AVG, S_MUL, S_WB, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NL, OP_NX, OP_SPRING, OP_ACC, OP_VEL, OP_CMD
  } op_t;

  typedef struct packed {
    logic [30:0] total;
    logic [16:0] mix;
    logic [30:0] adm;
    logic [30:0] stiff;
    logic [16:0] reach;
    logic [15:0] warm;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             seed;
    logic             avg;
    logic             mul;
    logic             wb;
    logic             fin;
    op_t              op;
    logic [LEG_W-1:0] leg;
  } dp_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic is_cons;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return hi[DW-1:0];
    else if (v < lo) return lo[DW-1:0];
    else return v[DW-1:0];
  endfunction

endpackage

/* rtl/cfa_ctrl.sv */
// ----------------------------------------------------------------------------
// cfa_ctrl: tick sequencer
// Walks seed / consensus / admittance steps, one shared multiply per op.
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfa_pkg::dp_stat_t stat,
  output cfa_pkg::dp_cmd_t  cmd
);
  import cfa_pkg::*;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [LEG_W-1:0] leg, leg_next;
  logic             last_leg;

  assign last_leg = (leg == LEG_W'(LEGS - 1));
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_SPRING;
      leg   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      leg   <= leg_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    leg_next   = leg;
    cmd        = '0;
    cmd.op     = op;
    cmd.leg    = leg;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        leg_next = '0;
        priority if (stat.is_seed) begin
          state_next = S_SEED;
          op_next    = OP_SPRING;
        end else if (stat.is_cons) begin
          state_next = S_AVG;
          op_next    = OP_NL;
        end else begin
          state_next = S_MUL;
          op_next    = OP_SPRING;
        end
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_MUL;
      end
      S_AVG: begin
        cmd.avg    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_MUL;
        unique case (op)
          OP_NL:  op_next = OP_NX;
          OP_NX: begin
            if (last_leg) begin
              op_next  = OP_SPRING;
              leg_next = '0;
            end else begin
              op_next  = OP_NL;
              leg_next = leg + 1'b1;
            end
          end
          OP_SPRING: op_next = OP_ACC;
          OP_ACC:    op_next = OP_VEL;
          OP_VEL:    op_next = OP_CMD;
          OP_CMD: begin
            if (last_leg) begin
              state_next = S_FIN;
            end else begin
              op_next  = OP_SPRING;
              leg_next = leg + 1'b1;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/cfa_dp.sv */
// ----------------------------------------------------------------------------
// cfa_dp: consensus and admittance datapath
// Per-leg state, one shared 32x32 multiplier with round/saturate, result reg.
// ----------------------------------------------------------------------------
module cfa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  cfa_pkg::cfg_t                     cfg,
  input  cfa_pkg::dp_cmd_t                  cmd,
  output cfa_pkg::dp_stat_t                 stat,
  input  logic signed [cfa_pkg::DW-1:0]     force_in [cfa_pkg::LEGS],
  input  logic signed [cfa_pkg::DW-1:0]     pos_in   [cfa_pkg::LEGS],
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [cfa_pkg::DW-1:0]     ref_out  [cfa_pkg::LEGS],
  output logic signed [cfa_pkg::DW-1:0]     cmd_out  [cfa_pkg::LEGS]
);
  import cfa_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic [15:0]          tick;
  logic signed [DW-1:0] force_q [LEGS];
  logic signed [DW-1:0] pos_q   [LEGS];
  logic signed [DW-1:0] sx [LEGS];   // share estimate
  logic signed [DW-1:0] sy [LEGS];   // disagreement
  logic signed [DW-1:0] sl [LEGS];   // multiplier
  logic signed [DW-1:0] sr [LEGS];   // reference force
  logic signed [DW-1:0] cmd_q [LEGS];
  logic signed [DW-1:0] avg_l, avg_y, tmp;
  logic signed [63:0]   prod;

  logic signed [DW-1:0] mul_a, mul_b, q, alpha, target, spring_in;
  logic signed [63:0]   rnd;
  logic signed [33:0]   sum_l, sum_y;
  logic signed [31:0]   share;

  assign stat.is_seed  = (tick == cfg.warm);
  assign stat.is_cons  = (tick > cfg.warm);
  assign stat.out_free = !out_valid || !out_stall;

  assign alpha  = (cmd.leg < LEG_W'(LEGS / 2)) ? DW'(ALPHA_LO) : DW'(ALPHA_HI);
  assign target = (cmd.leg < LEG_W'(LEGS / 2)) ? DW'({15'd0, cfg.reach})
                                                : -DW'({15'd0, cfg.reach});
  assign spring_in = sat32(64'(pos_q[cmd.leg]) - 64'(target));
  assign share     = 32'(({33'd0, cfg.total} + 64'd2) >> 2);

  always_comb begin
    sum_l = '0;
    sum_y = '0;
    for (int i = 0; i < LEGS; i++) begin
      sum_l = sum_l + 34'(sl[i]);
      sum_y = sum_y + 34'(sy[i]);
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_NL:     begin mul_a = DW'({15'd0, cfg.mix});  mul_b = sy[cmd.leg]; end
      OP_NX:     begin mul_a = alpha;                   mul_b = tmp;         end
      OP_SPRING: begin mul_a = DW'({1'b0, cfg.stiff}); mul_b = spring_in;   end
      OP_ACC:    begin mul_a = DW'({1'b0, cfg.adm});   mul_b = tmp;         end
      OP_VEL:    begin mul_a = DW'(TICK_Q);            mul_b = tmp;         end
      OP_CMD:    begin mul_a = DW'(TICK_Q);            mul_b = tmp;         end
      default:   begin mul_a = '0;                      mul_b = '0;          end
    endcase
  end

  assign rnd = (prod + HALF) >>> FRAC_BITS;
  assign q   = sat32(rnd);

  always_ff @(posedge clk) begin
    logic signed [DW-1:0] nx;
    logic signed [DW-1:0] nl;
    logic signed [63:0]   fa;
    if (rst) begin
      tick      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < LEGS; i++) begin
        sx[i] <= '0;
        sy[i] <= '0;
        sl[i] <= '0;
        sr[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        if (tick != 16'hFFFF) tick <= tick + 16'd1;
        for (int i = 0; i < LEGS; i++) begin
          force_q[i] <= force_in[i];
          pos_q[i]   <= pos_in[i];
        end
      end
      if (cmd.seed) begin
        for (int i = 0; i < LEGS; i++) begin
          sx[i] <= force_q[i];
          sy[i] <= sat32(64'(share) - 64'(force_q[i]));
          if (i < LEGS / 2) begin
            fa = 64'(force_q[i]) - ALPHA_LO;
            sl[i] <= sat32((fa <<< 3) + (fa <<< 1));
          end else begin
            fa = 64'(force_q[i]) - ALPHA_HI;
            sl[i] <= sat32((fa <<< 2) + fa);
          end
        end
      end
      if (cmd.avg) begin
        avg_l <= 32'((sum_l + 34'sd2) >>> 2);
        avg_y <= 32'((sum_y + 34'sd2) >>> 2);
      end
      if (cmd.mul) prod <= 64'(mul_a) * 64'(mul_b);
      if (cmd.wb) begin
        unique case (cmd.op)
          OP_NL: begin
            nl = sat32(64'(avg_l) + 64'(q));
            tmp          <= nl;
            sl[cmd.leg]  <= nl;
          end
          OP_NX: begin
            nx = sat32(64'(q) + 64'(alpha));
            sx[cmd.leg] <= nx;
            sr[cmd.leg] <= nx;
            sy[cmd.leg] <= sat32(64'(avg_y) - (64'(nx) - 64'(sx[cmd.leg])));
          end
          OP_SPRING: tmp <= sat32(64'(force_q[cmd.leg]) - 64'(sr[cmd.leg]) + 64'(q));
          OP_ACC:    tmp <= q;
          OP_VEL:    tmp <= q;
          OP_CMD:    cmd_q[cmd.leg] <= sat32(64'(pos_q[cmd.leg]) + 64'(q));
          default:   tmp <= tmp;
        endcase
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
        for (int i = 0; i < LEGS; i++) begin
          ref_out[i] <= sr[i];
          cmd_out[i] <= cmd_q[i];
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/consensus_force_admittance_core.sv */
// ----------------------------------------------------------------------------
// consensus_force_admittance_core: legged load sharing with admittance
// Consensus force distribution plus admittance-corrected foot x commands.
// ----------------------------------------------------------------------------
// One beat in per control tick, one beat out. Each tick bumps a saturating
// tick counter; on the warm-up tick the consensus state is seeded from the
// measured forces, after it every tick runs one consensus iteration that
// sets the four reference forces. Every tick then forms a commanded foot x
// per leg. All values are Q16.16 and saturate to signed 32 bits. Every
// product goes through one shared 32x32 multiplier, a multiply step then
// a round/saturate/write-back step, six products per leg with consensus
// and four without. The input takes one tick at a time; the result
// register lets the next tick start while the last result is still stalled.
// Configuration writes are accepted at any time but must only occur idle.
module consensus_force_admittance_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   force_lf,
  input  logic signed [31:0]   force_rf,
  input  logic signed [31:0]   force_lh,
  input  logic signed [31:0]   force_rh,
  input  logic signed [31:0]   pos_lf,
  input  logic signed [31:0]   pos_rf,
  input  logic signed [31:0]   pos_lh,
  input  logic signed [31:0]   pos_rh,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   ref_lf,
  output logic signed [31:0]   ref_rf,
  output logic signed [31:0]   ref_lh,
  output logic signed [31:0]   ref_rh,
  output logic signed [31:0]   cmd_lf,
  output logic signed [31:0]   cmd_rf,
  output logic signed [31:0]   cmd_lh,
  output logic signed [31:0]   cmd_rh
);
  import cfa_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [DW-1:0] force_v [LEGS];
  logic signed [DW-1:0] pos_v   [LEGS];
  logic signed [DW-1:0] ref_v   [LEGS];
  logic signed [DW-1:0] cmd_v   [LEGS];

  assign cfg_ready = 1'b1;

  // Register file, reset to defaults; writes are masked to field width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total <= 31'd655360;
      cfg.mix   <= 17'd58982;
      cfg.adm   <= 31'd65536;
      cfg.stiff <= 31'd32768;
      cfg.reach <= 17'd3080;
      cfg.warm  <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOTAL: cfg.total <= cfg_data[30:0];
        CFG_MIX:   cfg.mix   <= cfg_data[16:0];
        CFG_ADM:   cfg.adm   <= cfg_data[30:0];
        CFG_STIFF: cfg.stiff <= cfg_data[30:0];
        CFG_REACH: cfg.reach <= cfg_data[16:0];
        CFG_WARM:  cfg.warm  <= cfg_data[15:0];
        default:   cfg.warm  <= cfg.warm;  // unused index: ignored
      endcase
    end
  end

  // Leg order: LF, RF (front), LH, RH (hind).
  assign force_v[0] = force_lf;
  assign force_v[1] = force_rf;
  assign force_v[2] = force_lh;
  assign force_v[3] = force_rh;
  assign pos_v[0]   = pos_lf;
  assign pos_v[1]   = pos_rf;
  assign pos_v[2]   = pos_lh;
  assign pos_v[3]   = pos_rh;

  cfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .force_in  (force_v),
    .pos_in    (pos_v),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .ref_out   (ref_v),
    .cmd_out   (cmd_v)
  );

  assign ref_lf = ref_v[0];
  assign ref_rf = ref_v[1];
  assign ref_lh = ref_v[2];
  assign ref_rh = ref_v[3];
  assign cmd_lf = cmd_v[0];
  assign cmd_rf = cmd_v[1];
  assign cmd_lh = cmd_v[2];
  assign cmd_rh = cmd_v[3];

  // A tick beat taken closes the input until its result is registered.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a tick beat");

  // A new result only shows up at the end of a tick's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a tick in progress");

  // The sequencer only finishes into a free result register.
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

endmodule

/* tb/sv/consensus_force_admittance_core_test.sv */
// ----------------------------------------------------------------------------
// consensus_force_admittance_core_test: self-checking bench for the core
// Drives control ticks through the valid/stall input, predicts the reference
// forces and commanded foot x of every tick with a bit-exact Q16.16 model,
// and checks each result beat against it under random gaps and stalls.
// ----------------------------------------------------------------------------
module consensus_force_admittance_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on any channel
  localparam logic [2:0] CFG_NONE_LO = 3'd6;  // indexes past the register map
  localparam logic [2:0] CFG_NONE_HI = 3'd7;

  typedef struct {
    longint rf[4];
    longint cm[4];
  } tick_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] force_lf = '0, force_rf = '0, force_lh = '0, force_rh = '0;
  logic signed [31:0] pos_lf = '0, pos_rf = '0, pos_lh = '0, pos_rh = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] ref_lf, ref_rf, ref_lh, ref_rh;
  logic signed [31:0] cmd_lf, cmd_rf, cmd_lh, cmd_rh;

  consensus_force_admittance_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and consensus state of the predictor.
  longint total_q, mix_q, adm_q, stiff_q, reach_q, warm_q;
  int unsigned ticks;
  longint share_x[4], disagree_y[4], mult_l[4], ref_q[4];
  longint cur_force[4], cur_pos[4];

  tick_out_t want_q[$];
  int mismatches = 0;
  int fails = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int seed_ticks = 0;
  int cons_ticks = 0;
  bit quiet = 1'b0;   // suppresses random idling on both sides
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor((v + d/2) / d), d > 0
  function automatic longint div_round(longint v, longint d);
    longint w, q;
    w = v + d / 2;
    q = w / d;
    if ((w % d) != 0 && w < 0) q--;
    return q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat(div_round(a * b, Q_ONE));
  endfunction

  function automatic void reset_model();
    total_q = 655360; mix_q = 58982; adm_q = 65536;
    stiff_q = 32768; reach_q = 3080; warm_q = 100;
    ticks = 0;
    for (int i = 0; i < 4; i++) begin
      share_x[i] = 0; disagree_y[i] = 0; mult_l[i] = 0; ref_q[i] = 0;
    end
  endfunction

  // One control tick: seed or consensus step, then the admittance path.
  function automatic tick_out_t step_load_sharing();
    tick_out_t r;
    longint sl, sy, avg_l, avg_y, share, alpha, tgt, spring, err, acc, vel;
    longint nl[4], nx[4], ny[4];
    sl = 0;
    sy = 0;
    if (ticks < 65535) ticks++;
    if (longint'(ticks) == warm_q) begin
      seed_ticks++;
      share = div_round(total_q, 4);
      for (int i = 0; i < 4; i++) begin
        alpha = (i < 2) ? ALPHA_LO : ALPHA_HI;
        share_x[i] = cur_force[i];
        disagree_y[i] = sat(share - cur_force[i]);
        mult_l[i] = sat((cur_force[i] - alpha) * ((i < 2) ? 10 : 5));
      end
    end else if (longint'(ticks) > warm_q) begin
      cons_ticks++;
      for (int i = 0; i < 4; i++) begin
        sl += mult_l[i];
        sy += disagree_y[i];
      end
      avg_l = div_round(sl, 4);
      avg_y = div_round(sy, 4);
      for (int i = 0; i < 4; i++) begin
        alpha = (i < 2) ? ALPHA_LO : ALPHA_HI;
        nl[i] = sat(avg_l + qmul(mix_q, disagree_y[i]));
        nx[i] = sat(qmul(alpha, nl[i]) + alpha);
        ny[i] = sat(avg_y - (nx[i] - share_x[i]));
      end
      for (int i = 0; i < 4; i++) begin
        mult_l[i] = nl[i]; share_x[i] = nx[i];
        disagree_y[i] = ny[i]; ref_q[i] = nx[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      tgt = (i < 2) ? reach_q : -reach_q;
      spring = qmul(stiff_q, sat(cur_pos[i] - tgt));
      err = sat(cur_force[i] - ref_q[i] + spring);
      acc = qmul(adm_q, err);
      vel = qmul(acc, TICK_Q);
      r.rf[i] = ref_q[i];
      r.cm[i] = sat(cur_pos[i] + qmul(vel, TICK_Q));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    tick_out_t w;
    longint got[8];
    if (!rst && out_valid && !out_stall) begin
      got = '{ref_lf, ref_rf, ref_lh, ref_rh, cmd_lf, cmd_rf, cmd_lh, cmd_rh};
      if (want_q.size() == 0) begin
        fails++;
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with no tick outstanding");
      end else begin
        w = want_q.pop_front();
        beats_checked++;
        for (int i = 0; i < 8; i++) begin
          if (got[i] != ((i < 4) ? w.rf[i] : w.cm[i - 4])) begin
            fails++;
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: beat %0d %s_%s expected %0d got %0d", beats_checked,
                       (i < 4) ? "ref" : "cmd",
                       (i % 4 == 0) ? "lf" : (i % 4 == 1) ? "rf" : (i % 4 == 2) ? "lh" : "rh",
                       (i < 4) ? w.rf[i] : w.cm[i - 4], got[i]);
          end
        end
      end
    end
  end

  // Output back-pressure: mostly free, short stalls, the odd long one.
  always @(negedge clk) begin
    int r;
    if (rst || (quiet && stall_left == 0)) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall = 1'b0;
      end else if (r < 96) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall = 1'b1;
        stall_left = $urandom_range(10, 60);
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("consensus_force_admittance_core test failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------ drive tasks
  // All drive tasks start and end just after a falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TOTAL: total_q = val[30:0];
      CFG_MIX:   mix_q = val[16:0];
      CFG_ADM:   adm_q = val[30:0];
      CFG_STIFF: stiff_q = val[30:0];
      CFG_REACH: reach_q = val[16:0];
      CFG_WARM:  warm_q = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_tick();
    int r, gap;
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(30, 90);
    end
    repeat (gap) @(negedge clk);
    {force_lf, force_rf, force_lh, force_rh} =
      {32'(cur_force[0]), 32'(cur_force[1]), 32'(cur_force[2]), 32'(cur_force[3])};
    {pos_lf, pos_rf, pos_lh, pos_rh} =
      {32'(cur_pos[0]), 32'(cur_pos[1]), 32'(cur_pos[2]), 32'(cur_pos[3])};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    want_q.push_back(step_load_sharing());
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Let every outstanding tick drain before touching the registers.
  task automatic drain();
    while (want_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void plausible_tick();
    for (int i = 0; i < 4; i++) begin
      cur_force[i] = longint'($urandom_range(0, 200 << 16));
      cur_pos[i] = longint'($urandom_range(0, 2 << 16)) - (1 << 16);
    end
  endfunction

  function automatic void noise_tick();
    for (int i = 0; i < 4; i++) begin
      cur_force[i] = longint'($signed($urandom));
      cur_pos[i] = longint'($signed($urandom));
    end
  endfunction

  function automatic logic [31:0] pick_reg(int bits, logic [31:0] top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return top;
    if (r == 2) return $urandom;  // upper bits get masked off
    return $urandom_range(0, (bits > 17) ? (100 << 16) : top);
  endfunction

  // ------------------------------------------------------------- the tests
  // Pre-warm-up ticks at reset settings: only the admittance path runs.
  task automatic test_admittance_extremes();
    longint ext[6];
    ext = '{64'sd0, 64'sd1, -64'sd1, 64'sd2147483647, -64'sd2147483648, 64'sd65536};
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 4; i++) begin
        cur_force[i] = ext[(k + i) % 6];
        cur_pos[i] = ext[(k + 2 * i + 1) % 6];
      end
      send_tick();
    end
    drain();
  endtask

  // Every register written, seed a few ticks out, watch consensus run.
  task automatic test_seed_then_consensus();
    write_reg(CFG_TOTAL, 32'd400 << 16);
    write_reg(CFG_MIX, 32'd58982);
    write_reg(CFG_ADM, 32'd2 << 16);
    write_reg(CFG_STIFF, 32'd40000);
    write_reg(CFG_REACH, 32'd3080);
    write_reg(CFG_WARM, 32'(ticks + 2));
    for (int k = 0; k < 8; k++) begin
      plausible_tick();
      send_tick();
    end
    drain();
  endtask

  // Out-of-map indexes change nothing; warm-up of zero runs consensus at once.
  task automatic test_odd_registers();
    write_reg(CFG_NONE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_NONE_HI, 32'h1234_5678);
    write_reg(CFG_WARM, 32'h0001_0000);  // masks to zero
    for (int k = 0; k < 4; k++) begin
      noise_tick();
      send_tick();
    end
    drain();
  endtask

  // Extreme gains with saturating inputs during consensus.
  task automatic test_saturation();
    write_reg(CFG_TOTAL, 32'h7FFF_FFFF);
    write_reg(CFG_MIX, 32'd65536);
    write_reg(CFG_ADM, 32'h7FFF_FFFF);
    write_reg(CFG_STIFF, 32'h7FFF_FFFF);
    write_reg(CFG_REACH, 32'd65536);
    write_reg(CFG_WARM, 32'(ticks + 1));
    for (int k = 0; k < 6; k++) begin
      noise_tick();
      send_tick();
    end
    drain();
  endtask

  // After every fourth tick the sender holds off until the core has returned everything it owes.
  task automatic test_hold_off();
    for (int k = 0; k < 40; k++) begin
      plausible_tick();
      send_tick();
      if (k % 4 == 0) begin
        while (want_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    drain();
  endtask

  // Random phases: new settings, a seed a few ticks ahead (sometimes never or
  // already passed), then mostly plausible ticks with some raw noise.
  task automatic test_random_phases();
    int n, r;
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 5 == 3);
      write_reg(CFG_TOTAL, pick_reg(31, 32'h7FFF_FFFF));
      write_reg(CFG_MIX, pick_reg(17, 32'd65536));
      write_reg(CFG_ADM, pick_reg(31, 32'h7FFF_FFFF));
      write_reg(CFG_STIFF, pick_reg(31, 32'h7FFF_FFFF));
      write_reg(CFG_REACH, pick_reg(17, 32'd65536));
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_WARM, 32'd65535);
      else if (r == 1) write_reg(CFG_WARM, 32'd1);
      else write_reg(CFG_WARM, 32'(ticks + $urandom_range(1, 6)));
      n = $urandom_range(80, 120);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 8) plausible_tick();
        else noise_tick();
        send_tick();
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_admittance_extremes();
    test_seed_then_consensus();
    test_odd_registers();
    test_saturation();
    test_hold_off();
    test_random_phases();
    if (want_q.size() != 0) fails++;
    $display("covered %0d ticks, %0d result beats: %0d seed ticks, %0d consensus ticks",
             items_sent, beats_checked, seed_ticks, cons_ticks);
    $display("mismatches: %0d", mismatches);
    if (fails == 0) begin
      $display("consensus_force_admittance_core test passed");
    end else begin
      $display("consensus_force_admittance_core test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cfa_pkg.sv
rtl/cfa_ctrl.sv
rtl/cfa_dp.sv
rtl/consensus_force_admittance_core.sv
tb/sv/consensus_force_admittance_core_test.sv
